/* hw/rtl/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg
// Types and constants shared by the RGB to HSL converter and its testbench.
// ----------------------------------------------------------------------------
package rth_pkg;

    // Pixel in.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_rgb;

    // Colour out.
    typedef struct packed {
        logic [8:0] hue_deg;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } t_hsl;

    // Which channel holds the maximum, red tested first, then green.
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Divider geometry: numerators below 2^18, divisors below 2^9 and
    // quotients of at most nine bits (hue can round up to 360).
    localparam int NUM_W = 18;
    localparam int DEN_W = 9;
    localparam int QUO_W = 9;

    localparam int unsigned SUM_MID        = 255;
    localparam int unsigned SAT_SCALE2     = 510;
    localparam int unsigned HUE_STEP       = 60;
    localparam int unsigned HUE_GREEN_BASE = 120;
    localparam int unsigned HUE_BLUE_BASE  = 240;
    localparam int unsigned HUE_FULL       = 360;

endpackage

/* hw/rtl/rgb_to_hsl.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsl
// Converts an 8-bit RGB pixel into hue in degrees, saturation and lightness.
// ----------------------------------------------------------------------------
// The converter takes one pixel transfer per clock when the output side is
// not stalled. One stage finds the largest and smallest channel, one forms
// the numerators and divisors, nine stages of the pipelined divider settle
// one quotient bit each, and a final stage wraps the hue and registers the
// result. Each stage carries a valid bit and holds only while the stage
// after it is full and stalled, so an empty stage anywhere lets a new pixel
// in.
module rgb_to_hsl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rth_pkg::t_rgb    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rth_pkg::t_hsl    o_out_data
);

    localparam int NDIV = rth_pkg::QUO_W;
    localparam int NS   = NDIV + 3;

    logic [NS-1:0] r_vld;
    logic [NS:0]   ready;

    always_comb begin
        ready[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !r_vld[k] || ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ready[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = ready[0];
    assign o_out_valid = r_vld[NS-1];

    // ---- Stage A: extremes and sector ----
    logic [7:0]       n_a_mx, n_a_mn;
    rth_pkg::t_sector n_a_sec;
    logic [7:0]       r_a_red, r_a_green, r_a_blue, r_a_mx, r_a_mn;
    rth_pkg::t_sector r_a_sec;

    always_comb begin
        if (i_in_data.red_in >= i_in_data.green_in && i_in_data.red_in >= i_in_data.blue_in) begin
            n_a_sec = rth_pkg::SEC_RED;
            n_a_mx  = i_in_data.red_in;
        end else if (i_in_data.green_in >= i_in_data.blue_in) begin
            n_a_sec = rth_pkg::SEC_GREEN;
            n_a_mx  = i_in_data.green_in;
        end else begin
            n_a_sec = rth_pkg::SEC_BLUE;
            n_a_mx  = i_in_data.blue_in;
        end
        n_a_mn = i_in_data.red_in;
        if (i_in_data.green_in < n_a_mn) n_a_mn = i_in_data.green_in;
        if (i_in_data.blue_in < n_a_mn)  n_a_mn = i_in_data.blue_in;
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_a_red   <= i_in_data.red_in;
            r_a_green <= i_in_data.green_in;
            r_a_blue  <= i_in_data.blue_in;
            r_a_mx    <= n_a_mx;
            r_a_mn    <= n_a_mn;
            r_a_sec   <= n_a_sec;
        end
    end

    // ---- Stage B: numerators, divisors and lightness ----
    logic [7:0]                  b_d;
    logic [8:0]                  b_sm;
    logic signed [9:0]           b_diff;
    logic [16:0]                 b_base;
    logic signed [18:0]          b_num;
    logic [16:0]                 b_angle;
    logic [7:0]                  b_den;
    logic [9:0]                  b_sm1;
    logic [rth_pkg::NUM_W-1:0]   n_b_hn, n_b_sn;
    logic [rth_pkg::DEN_W-1:0]   n_b_hd, n_b_sd;

    logic [rth_pkg::NUM_W-1:0]   r_b_hn, r_b_sn;
    logic [rth_pkg::DEN_W-1:0]   r_b_hd, r_b_sd;
    logic [7:0]                  r_b_lig;
    logic                        r_b_grey;

    always_comb begin
        b_d  = r_a_mx - r_a_mn;
        b_sm = 9'(r_a_mx) + 9'(r_a_mn);
        case (r_a_sec)
            rth_pkg::SEC_RED: begin
                b_diff = $signed(10'(r_a_green)) - $signed(10'(r_a_blue));
                b_base = '0;
            end
            rth_pkg::SEC_GREEN: begin
                b_diff = $signed(10'(r_a_blue)) - $signed(10'(r_a_red));
                b_base = 17'(rth_pkg::HUE_GREEN_BASE * 32'(b_d));
            end
            rth_pkg::SEC_BLUE: begin
                b_diff = $signed(10'(r_a_red)) - $signed(10'(r_a_green));
                b_base = 17'(rth_pkg::HUE_BLUE_BASE * 32'(b_d));
            end
            default: begin
                b_diff = '0;
                b_base = '0;
            end
        endcase
        // Angle times the spread; only the red sector can go negative.
        b_num = $signed(19'(b_base))
              + 19'(b_diff) * $signed(19'(rth_pkg::HUE_STEP));
        if (b_num < 0) begin
            b_angle = 17'(b_num + $signed(19'(rth_pkg::HUE_FULL * 32'(b_d))));
        end else begin
            b_angle = b_num[16:0];
        end
        // Rounded quotient q = (2n + d) / (2d) for both outputs.
        n_b_hn = rth_pkg::NUM_W'({b_angle, 1'b0}) + rth_pkg::NUM_W'(b_d);
        n_b_hd = {b_d, 1'b0};

        if (b_sm < 9'(rth_pkg::SUM_MID)) begin
            b_den = b_sm[7:0];
        end else begin
            b_den = 8'(10'(rth_pkg::SAT_SCALE2) - 10'(b_sm));
        end
        n_b_sn = rth_pkg::NUM_W'(rth_pkg::SAT_SCALE2 * 32'(b_d)) + rth_pkg::NUM_W'(b_den);
        n_b_sd = {b_den, 1'b0};

        b_sm1 = 10'(b_sm) + 10'd1;
    end

    always_ff @(posedge i_clk) begin
        if (ready[1]) begin
            r_b_hn   <= n_b_hn;
            r_b_hd   <= n_b_hd;
            r_b_sn   <= n_b_sn;
            r_b_sd   <= n_b_sd;
            r_b_lig  <= b_sm1[8:1];
            r_b_grey <= (b_d == 8'd0);
        end
    end

    // ---- Divider stages ----
    logic [NDIV-1:0] div_en;
    logic [NDIV-1:0] q_hue, q_sat;

    assign div_en = ready[NDIV+1:2];

    rth_div_pipe #(
        .NUM_W (rth_pkg::NUM_W),
        .DEN_W (rth_pkg::DEN_W),
        .QUO_W (NDIV)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_num (r_b_hn),
        .i_den (r_b_hd),
        .o_quo (q_hue)
    );

    rth_div_pipe #(
        .NUM_W (rth_pkg::NUM_W),
        .DEN_W (rth_pkg::DEN_W),
        .QUO_W (NDIV)
    ) u_div_sat (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_num (r_b_sn),
        .i_den (r_b_sd),
        .o_quo (q_sat)
    );

    // Lightness and the grey flag ride alongside the divider.
    logic [7:0] r_s_lig  [NDIV];
    logic       r_s_grey [NDIV];

    always_ff @(posedge i_clk) begin
        if (div_en[0]) begin
            r_s_lig[0]  <= r_b_lig;
            r_s_grey[0] <= r_b_grey;
        end
        for (int j = 1; j < NDIV; j++) begin
            if (div_en[j]) begin
                r_s_lig[j]  <= r_s_lig[j-1];
                r_s_grey[j] <= r_s_grey[j-1];
            end
        end
    end

    // ---- Output stage ----
    rth_pkg::t_hsl n_out;
    rth_pkg::t_hsl r_out;

    always_comb begin
        n_out.lightness = r_s_lig[NDIV-1];
        if (r_s_grey[NDIV-1]) begin
            // A grey pixel has no hue and no saturation.
            n_out.hue_deg    = '0;
            n_out.saturation = '0;
        end else begin
            if (q_hue >= 9'(rth_pkg::HUE_FULL)) begin
                n_out.hue_deg = q_hue - 9'(rth_pkg::HUE_FULL);
            end else begin
                n_out.hue_deg = q_hue;
            end
            n_out.saturation = q_sat[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

/* hw/rtl/rth_div_pipe.sv */
// ----------------------------------------------------------------------------
// rth_div_pipe
// Pipelined restoring divider: one quotient bit is settled in each register
// stage, most significant bit first. Each stage advances on its own enable.
// ----------------------------------------------------------------------------
module rth_div_pipe #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 9,
    parameter int QUO_W = 9
) (
    input  logic             i_clk,
    input  logic [QUO_W-1:0] i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    // The caller guarantees num < den * 2^QUO_W, so the quotient fits.
    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [NUM_W-1:0] rem_prev;
        logic [DEN_W-1:0] den_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [NUM_W:0]   sh;
        logic [NUM_W:0]   diff;
        logic             take;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign rem_prev = i_num;
            assign den_prev = i_den;
            assign quo_prev = '0;
        end else begin : g_next
            assign rem_prev = r_rem[g-1];
            assign den_prev = r_den[g-1];
            assign quo_prev = r_quo[g-1];
        end

        always_comb begin
            sh    = (NUM_W+1)'(den_prev) << (QUO_W - 1 - g);
            diff  = (NUM_W+1)'(rem_prev) - sh;
            take  = (NUM_W+1)'(rem_prev) >= sh;
            n_rem = take ? diff[NUM_W-1:0] : rem_prev;
            n_quo = quo_prev;
            n_quo[QUO_W-1-g] = take;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[g]) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_prev;
                r_quo[g] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

/* sim/rgb_to_hsl_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_tb
// Self-checking bench for the RGB to HSL converter. Corner pixels go in
// first, then random pixels shaped towards greys, ties, small spans and the
// lightness midpoint. Each accepted pixel is converted in integer arithmetic
// by the bench and compared field by field with the result transfers, under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsl_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    logic           i_clk;
    logic           i_rst_n;
    logic           in_valid;
    logic           in_ready;
    rth_pkg::t_rgb  in_data;
    logic           out_valid;
    logic           out_ready;
    rth_pkg::t_hsl  out_data;

    int    send_idle_pct;
    int    stall_pct;
    int    cycle_count;

    // Rounds num/den to the nearest integer, halves going up.
    function automatic int unsigned rounded_quotient(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic rth_pkg::t_hsl convert_pixel(rth_pkg::t_rgb px);
        int               r, g, b, hi, lo, span, total, angle;
        rth_pkg::t_sector sector;
        rth_pkg::t_hsl    colour;
        r = int'(px.red_in);
        g = int'(px.green_in);
        b = int'(px.blue_in);
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        total = hi + lo;
        colour.lightness = 8'((total + 1) >> 1);
        colour.hue_deg = '0;
        colour.saturation = '0;
        if (span > 0) begin
            if (total < int'(rth_pkg::SUM_MID))
                colour.saturation = 8'(rounded_quotient(255 * span, total));
            else
                colour.saturation = 8'(rounded_quotient(255 * span,
                                                        rth_pkg::SAT_SCALE2 - total));
            if (hi == r) sector = rth_pkg::SEC_RED;
            else if (hi == g) sector = rth_pkg::SEC_GREEN;
            else sector = rth_pkg::SEC_BLUE;
            // The angle is held scaled by the span until the final rounding.
            case (sector)
                rth_pkg::SEC_RED: begin
                    angle = rth_pkg::HUE_STEP * (g - b);
                end
                rth_pkg::SEC_GREEN: begin
                    angle = rth_pkg::HUE_GREEN_BASE * span + rth_pkg::HUE_STEP * (b - r);
                end
                default: begin
                    angle = rth_pkg::HUE_BLUE_BASE * span + rth_pkg::HUE_STEP * (r - g);
                end
            endcase
            if (angle < 0) angle += rth_pkg::HUE_FULL * span;
            angle = rounded_quotient(angle, span);
            if (angle >= int'(rth_pkg::HUE_FULL)) angle -= rth_pkg::HUE_FULL;
            colour.hue_deg = 9'(angle);
        end
        return colour;
    endfunction

    class hsl_scoreboard;
        rth_pkg::t_hsl expected_q[$];
        int            fail_count = 0;

        task report(string what, int got, int want);
            $display("Mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
            fail_count++;
        endtask

        function void note_pixel(rth_pkg::t_rgb px);
            expected_q.push_back(convert_pixel(px));
        endfunction

        task check_colour(rth_pkg::t_hsl got);
            rth_pkg::t_hsl want;
            if (expected_q.size() == 0) begin
                report("result with no pixel pending, hue", int'(got.hue_deg), -1);
            end else begin
                want = expected_q.pop_front();
                if (got.hue_deg !== want.hue_deg)
                    report("hue_deg", int'(got.hue_deg), int'(want.hue_deg));
                if (got.saturation !== want.saturation)
                    report("saturation", int'(got.saturation), int'(want.saturation));
                if (got.lightness !== want.lightness)
                    report("lightness", int'(got.lightness), int'(want.lightness));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    hsl_scoreboard sb = new;

    rgb_to_hsl DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_colour(out_data);
    end

    task send_pixel(rth_pkg::t_rgb px);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_pixel(px);
    endtask

    // Lowers valid and holds off until every pending result has been seen.
    task drain;
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic rth_pkg::t_rgb random_pixel();
        rth_pkg::t_rgb px;
        int            base;
        px = rth_pkg::t_rgb'(24'($urandom));
        case ($urandom_range(9))
            5: begin
                px.green_in = px.red_in;
                px.blue_in  = px.red_in;
            end
            6: begin
                // Two channels tied, which exercises the sector priority.
                if ($urandom_range(1)) px.green_in = px.red_in;
                else px.blue_in = px.green_in;
            end
            7: begin
                base = $urandom_range(252, 2);
                px.red_in   = 8'(base);
                px.green_in = 8'(base + $urandom_range(3));
                px.blue_in  = 8'(base - $urandom_range(2));
            end
            8: begin
                px.red_in   = $urandom_range(1) ? 8'hFF : 8'h00;
                px.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
                if ($urandom_range(1)) px.blue_in = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            9: begin
                // Keeps max plus min close to the saturation formula switch.
                base = $urandom_range(254, 1);
                px.red_in   = 8'(base);
                px.green_in = 8'(255 - base + $urandom_range(2) - 1);
                px.blue_in  = 8'($urandom_range(255 - base, base < 128 ? base : 255 - base));
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    task run_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count) send_pixel(random_pixel());
        drain();
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Greys, primaries, ties, the hue wrap to zero and the lightness midpoint.
        send_pixel('{8'd0,   8'd0,   8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd128, 8'd128, 8'd128});
        send_pixel('{8'd255, 8'd0,   8'd0});
        send_pixel('{8'd0,   8'd255, 8'd0});
        send_pixel('{8'd0,   8'd0,   8'd255});
        send_pixel('{8'd255, 8'd255, 8'd0});
        send_pixel('{8'd0,   8'd255, 8'd255});
        send_pixel('{8'd255, 8'd0,   8'd255});
        send_pixel('{8'd255, 8'd0,   8'd1});
        send_pixel('{8'd1,   8'd0,   8'd0});
        send_pixel('{8'd254, 8'd0,   8'd0});
        send_pixel('{8'd200, 8'd54,  8'd100});
        send_pixel('{8'd200, 8'd55,  8'd100});
        send_pixel('{8'd100, 8'd93,  8'd92});
        send_pixel('{8'd255, 8'd254, 8'd254});
        send_pixel('{8'd170, 8'd85,  8'd0});
        send_pixel('{8'd0,   8'd128, 8'd255});
        send_pixel('{8'd255, 8'd1,   8'd0});
        send_pixel('{8'd1,   8'd0,   8'd1});
        drain();

        run_phase(260, 0, 0);
        run_phase(260, 46, 0);
        run_phase(260, 0, 46);
        run_phase(260, 8, 8);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
